// ===== hw/rtl/pip_pkg.sv =====
// Shared types for the point-in-polygon test block.
// Used by pip_front, pip_queue, pip_back and point_in_polygon_test.
package pip_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } pip_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } pip_state_e;

  // Result beat leaving the back end.
  typedef struct packed {
    logic valid;
    logic hit;
  } pip_res_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic idle;
    logic pipe_busy;
  } pip_stat_t;

  // Entries of the command queue between front and back.
  localparam int unsigned QueueDepth = 2;

endpackage

// ===== hw/rtl/pip_front.sv =====
// Front end: accepts command beats, drops out-of-range vertex writes,
// packs commands for the queue and holds the vertex count register. Uses pip_pkg.
module pip_front #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned AW           = 8,
  parameter int unsigned CW           = 9,
  parameter int unsigned QW           = 1 + AW + 2 * COORD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 operation_i,
  input  logic [7:0]           vertex_index_i,
  input  logic [31:0]          coord_x_i,
  input  logic [31:0]          coord_y_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [8:0]           cfg_data_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output logic [QW-1:0]        q_data_o,
  output logic [CW-1:0]        count_o
);

  logic [AW+7:0]  slot_ext;
  logic           in_range;
  logic           keep;
  logic [CW+8:0]  cnt_ext;
  logic [CW+8:0]  cnt_lim;
  logic [CW-1:0]  count_d, count_q;
  pip_pkg::pip_op_e op;

  assign op       = pip_pkg::pip_op_e'(operation_i);
  assign slot_ext = (AW + 8)'(vertex_index_i);
  assign in_range = slot_ext < (AW + 8)'(MAX_VERTICES);
  assign keep     = (op == pip_pkg::OP_QUERY) || in_range;

  assign busy     = q_full_i;
  assign q_push_o = start && !q_full_i && keep;
  assign q_data_o = {operation_i, slot_ext[AW-1:0],
                     coord_x_i[COORD_WIDTH-1:0], coord_y_i[COORD_WIDTH-1:0]};

  // Clamp the count to the vertex capacity.
  assign cfg_ready_o = 1'b1;
  assign cnt_ext     = (CW + 9)'(cfg_data_i);
  assign cnt_lim     = (CW + 9)'(MAX_VERTICES);
  assign count_d     = (cnt_ext > cnt_lim) ? cnt_lim[CW-1:0] : cnt_ext[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ===== hw/rtl/pip_queue.sv =====
// Short command queue between front and back end.
// Register-based FIFO; depth comes from pip_pkg.
module pip_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             nonempty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned Depth = pip_pkg::QueueDepth;
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW    = $clog2(Depth + 1);

  logic [WIDTH-1:0] slot_q [Depth];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    fill_q;

  assign full_o     = (fill_q == NW'(Depth));
  assign nonempty_o = (fill_q != '0);
  assign data_o     = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/pip_back.sv =====
// Back end: vertex memory, edge walk sequencer and three-stage crossing test.
// Uses pip_pkg for the state, result and status types.
module pip_back #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned AW           = 8,
  parameter int unsigned CW           = 9,
  parameter int unsigned QW           = 1 + AW + 2 * COORD_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  logic [QW-1:0]       q_data_i,
  output logic                q_pop_o,
  input  logic [CW-1:0]       count_i,
  output pip_pkg::pip_res_t   res_o,
  output pip_pkg::pip_stat_t  stat_o
);

  localparam int unsigned C = COORD_WIDTH;

  pip_pkg::pip_state_e state_d, state_q;
  pip_pkg::pip_op_e    op;
  pip_pkg::pip_res_t   res_d, res_q;

  logic [AW-1:0] wr_addr;
  logic [C-1:0]  in_x, in_y;

  logic [C-1:0]  mem_x [MAX_VERTICES];
  logic [C-1:0]  mem_y [MAX_VERTICES];

  logic          wr_en, rd_en, start_walk;
  logic [CW-1:0] k_d, k_q, n_q, rd_idx;
  logic [C-1:0]  px_q, py_q;

  logic          rv_q, rfirst_q, rlast_q;
  logic [C-1:0]  rd_x_q, rd_y_q, prev_x_q, prev_y_q;

  logic signed [C:0] dif_a, dif_d, dif_b, dif_c;
  logic [C:0]        abs_a, abs_d, abs_b, abs_c;
  logic              straddle;

  logic          s1_v_q, s1_last_q, s1_str_q, s1_dpos_q, s1_lneg_q, s1_rneg_q;
  logic [C-1:0]  ma_q, md_q, mb_q, mc_q;

  logic          s2_v_q, s2_last_q, s2_str_q, s2_dpos_q, s2_lneg_q, s2_rneg_q;
  logic [2*C-1:0] pl_q, pr_q;

  logic          mag_lt, mag_gt, l_less_r, r_less_l, left, toggle, parity_q;

  // Unpack the queue head.
  assign op      = pip_pkg::pip_op_e'(q_data_i[QW-1]);
  assign wr_addr = q_data_i[QW-2 -: AW];
  assign in_x    = q_data_i[2*C-1 -: C];
  assign in_y    = q_data_i[C-1:0];

  // Walk order: the closing vertex first, then slot 0 upward.
  assign rd_idx = (k_q == '0) ? n_q - 1'b1 : k_q - 1'b1;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    q_pop_o    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    start_walk = 1'b0;
    res_d      = '0;
    unique case (state_q)
      pip_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (op == pip_pkg::OP_WRITE) begin
            wr_en = 1'b1;
          end else if (count_i == '0) begin
            res_d.valid = 1'b1;
          end else begin
            start_walk = 1'b1;
            k_d        = '0;
            state_d    = pip_pkg::ST_WALK;
          end
        end
      end
      pip_pkg::ST_WALK: begin
        rd_en = 1'b1;
        k_d   = k_q + 1'b1;
        if (k_q == n_q) begin
          state_d = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (s2_v_q && s2_last_q) begin
          state_d = pip_pkg::ST_IDLE;
        end
      end
      default: state_d = pip_pkg::ST_IDLE;
    endcase
    if (s2_v_q && s2_last_q) begin
      res_d.valid = 1'b1;
      res_d.hit   = parity_q ^ toggle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pip_pkg::ST_IDLE;
      k_q     <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      res_q   <= res_d;
    end
  end

  // Vertex memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr] <= in_x;
      mem_y[wr_addr] <= in_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_x_q <= mem_x[rd_idx[AW-1:0]];
      rd_y_q <= mem_y[rd_idx[AW-1:0]];
    end
  end

  // Query point and vertex count hold for the whole walk.
  always_ff @(posedge clk_i) begin
    if (start_walk) begin
      px_q <= in_x;
      py_q <= in_y;
      n_q  <= count_i;
    end
  end

  // Stage 1: edge differences, straddle test and magnitudes.
  always_comb begin
    dif_a    = $signed({px_q[C-1], px_q})     - $signed({rd_x_q[C-1], rd_x_q});
    dif_d    = $signed({prev_y_q[C-1], prev_y_q}) - $signed({rd_y_q[C-1], rd_y_q});
    dif_b    = $signed({prev_x_q[C-1], prev_x_q}) - $signed({rd_x_q[C-1], rd_x_q});
    dif_c    = $signed({py_q[C-1], py_q})     - $signed({rd_y_q[C-1], rd_y_q});
    abs_a    = dif_a[C] ? -dif_a : dif_a;
    abs_d    = dif_d[C] ? -dif_d : dif_d;
    abs_b    = dif_b[C] ? -dif_b : dif_b;
    abs_c    = dif_c[C] ? -dif_c : dif_c;
    straddle = ($signed(rd_y_q) > $signed(py_q)) != ($signed(prev_y_q) > $signed(py_q));
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
    ma_q      <= abs_a[C-1:0];
    md_q      <= abs_d[C-1:0];
    mb_q      <= abs_b[C-1:0];
    mc_q      <= abs_c[C-1:0];
    s1_last_q <= rlast_q;
    s1_str_q  <= straddle;
    s1_dpos_q <= !dif_d[C] && (dif_d != '0);
    s1_lneg_q <= (dif_a[C] != dif_d[C]) && (dif_a != '0) && (dif_d != '0);
    s1_rneg_q <= (dif_b[C] != dif_c[C]) && (dif_b != '0) && (dif_c != '0);
  end

  // Stage 2: the two cross products as magnitudes.
  always_ff @(posedge clk_i) begin
    pl_q      <= (2 * C)'(ma_q) * (2 * C)'(md_q);
    pr_q      <= (2 * C)'(mb_q) * (2 * C)'(mc_q);
    s2_last_q <= s1_last_q;
    s2_str_q  <= s1_str_q;
    s2_dpos_q <= s1_dpos_q;
    s2_lneg_q <= s1_lneg_q;
    s2_rneg_q <= s1_rneg_q;
  end

  // Stage 3: signed compare picks the side of the crossing.
  assign mag_lt   = pl_q < pr_q;
  assign mag_gt   = pl_q > pr_q;
  assign l_less_r = (s2_lneg_q != s2_rneg_q) ? s2_lneg_q : (s2_lneg_q ? mag_gt : mag_lt);
  assign r_less_l = (s2_lneg_q != s2_rneg_q) ? s2_rneg_q : (s2_rneg_q ? mag_lt : mag_gt);
  assign left     = s2_dpos_q ? l_less_r : r_less_l;
  assign toggle   = s2_v_q && s2_str_q && left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q     <= 1'b0;
      rfirst_q <= 1'b0;
      rlast_q  <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      rv_q     <= rd_en;
      rfirst_q <= (k_q == '0);
      rlast_q  <= (k_q == n_q);
      s1_v_q   <= rv_q && !rfirst_q;
      s2_v_q   <= s1_v_q;
      if (start_walk) begin
        parity_q <= 1'b0;
      end else begin
        parity_q <= parity_q ^ toggle;
      end
    end
  end

  assign res_o            = res_q;
  assign stat_o.idle      = (state_q == pip_pkg::ST_IDLE);
  assign stat_o.pipe_busy = rv_q || s1_v_q || s2_v_q;

endmodule

// ===== hw/rtl/point_in_polygon_test.sv =====
// Top level of the ray-casting point-in-polygon test.
// Instantiates pip_front, pip_queue and pip_back; types from pip_pkg.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+----------------------------------
//  command   | in        | start high, busy low         | operation, vertex_index, coords
//  result    | out       | result_valid_o, one cycle    | inside_res_o
//  config    | in        | cfg_valid_i and cfg_ready_o  | cfg_data_i = vertex_count
//
// A command beat is taken whenever the two-entry queue has room, so the
// front keeps taking beats while the back end walks a polygon.
// A vertex write waits in the queue and reaches vertex memory once the idle
// back end pops it. During a query the single read port of vertex memory
// delivers one vertex per cycle (the closing vertex first, then slot 0 upward),
// then three stages of subtract, multiply and compare follow. A query with a
// vertex count of zero is answered without a walk, with inside_res_o low.
// Reset clears the queue, the sequencer and the count; vertex memory is not
// cleared. The receiver cannot stall: each result beat is shown for one cycle.
module point_in_polygon_test #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [7:0]  vertex_index_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  output logic        result_valid_o,
  output logic        inside_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);

  // Slot address width and count width (the count must hold the capacity).
  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned QW = 1 + AW + 2 * COORD_WIDTH;

  logic               q_push, q_full, q_pop, q_nonempty;
  logic [QW-1:0]      q_wdata, q_rdata;
  logic [CW-1:0]      count;
  pip_pkg::pip_res_t  res;
  pip_pkg::pip_stat_t stat;

  // Accept beats, drop writes beyond capacity, hold the count register.
  pip_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH),
    .AW           (AW),
    .CW           (CW),
    .QW           (QW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .vertex_index_i (vertex_index_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata),
    .count_o        (count)
  );

  // Decouple the front from the walk.
  pip_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .data_i     (q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .data_o     (q_rdata)
  );

  // Store vertices and walk edges for queries.
  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH),
    .AW           (AW),
    .CW           (CW),
    .QW           (QW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_nonempty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .count_i   (count),
    .res_o     (res),
    .stat_o    (stat)
  );

  assign result_valid_o = res.valid;
  assign inside_res_o   = res.hit;

  // A pushed beat is in the queue on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |=> q_nonempty)
    else $error("queue lost a pushed beat");

  // The back end pops only what is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_nonempty)
    else $error("pop from an empty queue");

  // Once the sequencer is idle, no edge is left in the crossing pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat.idle |-> !stat.pipe_busy)
    else $error("edge in flight while the back end is idle");

  // A result beat that ends a walk shows only once the sequencer is back in idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (result_valid_o && !$past(stat.idle)) |-> stat.idle)
    else $error("result beat before the walk finished");

endmodule
